[rtl/mkpd_pkg.sv]
package mkpd_pkg;

    localparam int unsigned MAX_COLUMNS = 8;
    localparam int unsigned MAX_ROWS    = 8;
    localparam int unsigned TABLE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
    localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
    localparam int unsigned CODE_W      = 7;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned LEVEL_W     = 8;

    typedef enum logic [1:0] {
        ACT_SCAN = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_READ = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_PRESS = 2'd0,
        KIND_PEEK  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_COLUMN_COUNT = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_PUSH_MODE    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_SCAN,
        ST_FETCH,
        ST_FLUSH
    } state_t;

endpackage

[rtl/matrix_keypad_press_detector_core.sv]
// Matrix keypad press detector core.
// A scan is accepted, visits each column in use in turn, passes through a fetch state for
// each press found, and ends in a flush state; a peek or a read goes through the reply state.
// One request at a time: no new request is taken until the last one has finished, and the
// single column walker reads each key's code through the code memory's registered port.
// Reset: rst_n clears every released flag to released, the holding register and its flag.
module matrix_keypad_press_detector_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream: tdata = action[1:0], row[4:2], column_levels[12:5],
    // key_index[18:13], key_value[25:19], zero fill [31:26].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Master stream: tdata = code[6:0], available[7].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // tuser = kind[1:0].
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);

    localparam int unsigned IDX_W   = mkpd_pkg::IDX_W;
    localparam int unsigned COL_W   = mkpd_pkg::COL_W;
    localparam int unsigned ROW_W   = mkpd_pkg::ROW_W;
    localparam int unsigned CODE_W  = mkpd_pkg::CODE_W;
    localparam int unsigned COUNT_W = mkpd_pkg::COUNT_W;
    localparam int unsigned LEVEL_W = mkpd_pkg::LEVEL_W;
    localparam int unsigned DEPTH   = mkpd_pkg::TABLE_DEPTH;

    // Request fields as they sit in tdata.
    mkpd_pkg::action_t   in_action;
    logic [ROW_W-1:0]    in_row;
    logic [LEVEL_W-1:0]  in_levels;
    logic [IDX_W-1:0]    in_key_index;
    logic [CODE_W-1:0]   in_key_value;

    assign in_action    = mkpd_pkg::action_t'(s_tdata[1:0]);
    assign in_row       = s_tdata[4:2];
    assign in_levels    = s_tdata[12:5];
    assign in_key_index = s_tdata[18:13];
    assign in_key_value = s_tdata[25:19];

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    logic [COUNT_W-1:0] column_count_reg;
    logic [COUNT_W-1:0] row_count_reg;
    logic               push_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COUNT_W'(mkpd_pkg::MAX_COLUMNS);
            row_count_reg    <= COUNT_W'(mkpd_pkg::MAX_ROWS);
            push_mode_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (mkpd_pkg::cfg_reg_t'(cfg_index))
                mkpd_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                mkpd_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                mkpd_pkg::REG_PUSH_MODE:    push_mode_reg    <= cfg_wdata[0];
                default:                    ;
            endcase
        end
    end

    // Counts above the supported maximum saturate.
    logic [COUNT_W-1:0] ncols_sat;
    logic [COUNT_W-1:0] nrows_sat;
    assign ncols_sat = (column_count_reg > COUNT_W'(mkpd_pkg::MAX_COLUMNS))
                     ? COUNT_W'(mkpd_pkg::MAX_COLUMNS) : column_count_reg;
    assign nrows_sat = (row_count_reg > COUNT_W'(mkpd_pkg::MAX_ROWS))
                     ? COUNT_W'(mkpd_pkg::MAX_ROWS) : row_count_reg;

    // Key code memory: one write port for loads, one registered read port for the walker.
    logic [CODE_W-1:0] code_mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    always_ff @(posedge clk)
    begin
        if (s_accept && in_action == mkpd_pkg::ACT_LOAD)
        begin
            code_mem[in_key_index] <= in_key_value;
        end
        rd_data_reg <= code_mem[idx_reg];
    end

    // Sequencer state and working registers.
    mkpd_pkg::state_t    state_reg, state_next;
    mkpd_pkg::kind_t     kind_reg, kind_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COUNT_W-1:0]  ncols_reg, ncols_next;
    logic [LEVEL_W-1:0]  levels_reg, levels_next;
    logic [DEPTH-1:0]    released_reg, released_next;
    logic [CODE_W-1:0]   held_code_reg, held_code_next;
    logic                held_avail_reg, held_avail_next;

    // A found press waits here until the next press or the end of the row tells
    // whether it is the final result of the request.
    logic                stage_valid_reg, stage_valid_next;
    logic [CODE_W-1:0]   stage_code_reg, stage_code_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic                out_avail_reg, out_avail_next;
    mkpd_pkg::kind_t     out_kind_reg, out_kind_next;
    logic                out_last_reg, out_last_next;

    logic out_free;
    logic level;
    logic press;
    logic last_col;

    assign out_free = !out_valid_reg || m_tready;
    assign level    = levels_reg[col_reg];
    assign press    = !level && released_reg[idx_reg];
    assign last_col = ({1'b0, col_reg} + COUNT_W'(1)) == ncols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mkpd_pkg::ST_IDLE;
            released_reg    <= '1;
            held_code_reg   <= '0;
            held_avail_reg  <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            released_reg    <= released_next;
            held_code_reg   <= held_code_next;
            held_avail_reg  <= held_avail_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        col_reg        <= col_next;
        idx_reg        <= idx_next;
        ncols_reg      <= ncols_next;
        levels_reg     <= levels_next;
        stage_code_reg <= stage_code_next;
        out_code_reg   <= out_code_next;
        out_avail_reg  <= out_avail_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        col_next         = col_reg;
        idx_next         = idx_reg;
        ncols_next       = ncols_reg;
        levels_next      = levels_reg;
        released_next    = released_reg;
        held_code_next   = held_code_reg;
        held_avail_next  = held_avail_reg;
        stage_valid_next = stage_valid_reg;
        stage_code_next  = stage_code_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_code_next    = out_code_reg;
        out_avail_next   = out_avail_reg;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;
        s_tready         = 1'b0;

        unique case (state_reg)
            mkpd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (in_action)
                        mkpd_pkg::ACT_SCAN:
                        begin
                            col_next    = '0;
                            ncols_next  = ncols_sat;
                            levels_next = in_levels;
                            // Row base of the key index; the walker steps it by one.
                            idx_next    = IDX_W'(in_row) * IDX_W'(ncols_sat);
                            if ({1'b0, in_row} < nrows_sat && ncols_sat != '0)
                            begin
                                state_next = mkpd_pkg::ST_SCAN;
                            end
                        end
                        mkpd_pkg::ACT_LOAD:
                        begin
                            // The write itself happens in the memory block.
                        end
                        mkpd_pkg::ACT_PEEK:
                        begin
                            kind_next  = mkpd_pkg::KIND_PEEK;
                            state_next = mkpd_pkg::ST_REPLY;
                        end
                        mkpd_pkg::ACT_READ:
                        begin
                            kind_next  = mkpd_pkg::KIND_READ;
                            state_next = mkpd_pkg::ST_REPLY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            mkpd_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = held_code_reg;
                    out_avail_next = held_avail_reg;
                    out_kind_next  = kind_reg;
                    out_last_next  = 1'b1;
                    if (kind_reg == mkpd_pkg::KIND_READ)
                    begin
                        held_avail_next = 1'b0;
                    end
                    state_next = mkpd_pkg::ST_IDLE;
                end
            end

            mkpd_pkg::ST_SCAN:
            begin
                // The key's flag follows the level; its code is read this same cycle.
                released_next[idx_reg] = level;
                if (press)
                begin
                    state_next = mkpd_pkg::ST_FETCH;
                end
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = last_col ? mkpd_pkg::ST_FLUSH : mkpd_pkg::ST_SCAN;
                end
            end

            mkpd_pkg::ST_FETCH:
            begin
                if (!push_mode_reg)
                begin
                    held_code_next  = rd_data_reg;
                    held_avail_next = 1'b1;
                    col_next        = col_reg + COL_W'(1);
                    idx_next        = idx_reg + IDX_W'(1);
                    state_next      = last_col ? mkpd_pkg::ST_FLUSH : mkpd_pkg::ST_SCAN;
                end
                else if (!stage_valid_reg || out_free)
                begin
                    if (stage_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_code_next  = stage_code_reg;
                        out_avail_next = held_avail_reg;
                        out_kind_next  = mkpd_pkg::KIND_PRESS;
                        out_last_next  = 1'b0;
                    end
                    stage_valid_next = 1'b1;
                    stage_code_next  = rd_data_reg;
                    col_next         = col_reg + COL_W'(1);
                    idx_next         = idx_reg + IDX_W'(1);
                    state_next       = last_col ? mkpd_pkg::ST_FLUSH : mkpd_pkg::ST_SCAN;
                end
            end

            mkpd_pkg::ST_FLUSH:
            begin
                if (!stage_valid_reg)
                begin
                    state_next = mkpd_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = stage_code_reg;
                    out_avail_next   = held_avail_reg;
                    out_kind_next    = mkpd_pkg::KIND_PRESS;
                    out_last_next    = 1'b1;
                    stage_valid_next = 1'b0;
                    state_next       = mkpd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mkpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_avail_reg, out_code_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A staged press never outlives its scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mkpd_pkg::ST_IDLE |-> !stage_valid_reg)
        else $error("staged press left behind after scan");

    // Presses are staged only for push mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> push_mode_reg)
        else $error("press staged in buffer mode");

    // The column walker stays inside the columns in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mkpd_pkg::ST_SCAN || state_reg == mkpd_pkg::ST_FETCH)
        |-> ({1'b0, col_reg} < ncols_reg))
        else $error("column walker beyond the columns in use");
`endif

endmodule
